### design/ilist_pkg.sv
// Shared package of the indexed list core: sizes, operation codes and the
// command and status structs between controller and datapath.
// No dependencies.
package ilist_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = 9;
   localparam int DATA_W   = 32;

   localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);
   localparam logic signed [DATA_W-1:0] READ_FAIL = '1;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // read address source of the storage port
   typedef enum logic [1:0] {
      RD_POS  = 2'd0,
      RD_PREV = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   // value placed in the response register
   typedef enum logic [1:0] {
      RSP_ZERO = 2'd0,
      RSP_DATA = 2'd1,
      RSP_FAIL = 2'd2
   } rsp_sel_type;

   typedef struct packed {
      logic        load;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      logic        wr_shift;
      logic        idx_set_cnt;
      logic        idx_set_pos;
      logic        idx_inc;
      logic        idx_dec;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        rsp_en;
      logic        rsp_ok;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   read_ok;
      logic   ins_ok;
      logic   del_ok;
      logic   idx_at_pos;
      logic   idx_last;
   } status_type;

endpackage

### design/ilist_datapath.sv
// Datapath of the indexed list core: entry storage, count, shift index,
// request latch and response registers.
// Depends on ilist_pkg.
module ilist_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ilist_pkg::cmd_type               cmd,
   output ilist_pkg::status_type            status,
   input  logic [1:0]                       req_op,
   input  logic [ilist_pkg::POS_W-1:0]      req_position,
   input  logic signed [ilist_pkg::DATA_W-1:0] req_item_value,
   output logic                             rsp_strobe,
   output logic signed [ilist_pkg::DATA_W-1:0] rsp_read_value,
   output logic                             rsp_ok,
   output logic [ilist_pkg::POS_W-1:0]      rsp_entry_count
);
   import ilist_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;

   op_type            op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] value_ff;
   logic [POS_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]  rd_addr;
   logic [DATA_W-1:0] wr_data;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_ok_ff;
   logic [POS_W-1:0]  rsp_count_ff;

   // decode the latched request against the count
   always_comb begin
      status.op         = op_ff;
      status.read_ok    = (pos_ff < count_ff);
      status.del_ok     = (pos_ff < count_ff);
      status.ins_ok     = (pos_ff <= count_ff) && (count_ff < CAP_COUNT);
      status.idx_at_pos = (idx_ff == pos_ff);
      status.idx_last   = ((idx_ff + POS_W'(1)) == count_ff);
   end

   // select storage addresses and write data
   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV: rd_addr = idx_ff - POS_W'(1);
         RD_NEXT: rd_addr = idx_ff + POS_W'(1);
         default: rd_addr = pos_ff;
      endcase
      wr_data = cmd.wr_shift ? rdata_ff : value_ff;
   end

   // storage with one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr[ADDR_W-1:0]];
      end
   end

   // next count and shift index
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) count_in = count_ff + POS_W'(1);
      if (cmd.cnt_dec) count_in = count_ff - POS_W'(1);
      idx_in = idx_ff;
      priority if (cmd.idx_set_cnt) idx_in = count_ff;
      else if (cmd.idx_set_pos)     idx_in = pos_ff;
      else if (cmd.idx_inc)         idx_in = idx_ff + POS_W'(1);
      else if (cmd.idx_dec)         idx_in = idx_ff - POS_W'(1);
   end

   always_comb begin
      unique case (cmd.rsp_sel)
         RSP_DATA: rsp_value_in = rdata_ff;
         RSP_FAIL: rsp_value_in = READ_FAIL;
         default:  rsp_value_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   // hold request, index and response payload
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         pos_ff   <= req_position;
         value_ff <= req_item_value;
      end
      if (cmd.rsp_en) begin
         rsp_value_ff <= rsp_value_in;
         rsp_ok_ff    <= cmd.rsp_ok;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

### design/ilist_ctrl.sv
// Controller of the indexed list core: sequences checks, shifts and the
// response through commands to the datapath.
// Depends on ilist_pkg.
module ilist_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ilist_pkg::status_type status,
   output ilist_pkg::cmd_type    cmd
);
   import ilist_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ_WAIT,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_WR
   } state_type;

   state_type state_ff, state_in;

   // decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (status.op)
               OP_READ: begin
                  if (status.read_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     state_in   = S_READ_WAIT;
                  end else begin
                     cmd.rsp_en  = 1'b1;
                     cmd.rsp_sel = RSP_FAIL;
                     state_in    = S_IDLE;
                  end
               end
               OP_INSERT: begin
                  if (status.ins_ok) begin
                     cmd.idx_set_cnt = 1'b1;
                     state_in        = S_INS_RD;
                  end else begin
                     cmd.rsp_en = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               OP_DELETE: begin
                  if (status.del_ok) begin
                     cmd.idx_set_pos = 1'b1;
                     state_in        = S_DEL_RD;
                  end else begin
                     cmd.rsp_en = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  cmd.rsp_en = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_READ_WAIT: begin
            cmd.rsp_en  = 1'b1;
            cmd.rsp_ok  = 1'b1;
            cmd.rsp_sel = RSP_DATA;
            state_in    = S_IDLE;
         end
         S_INS_RD: begin
            // place the new value once the gap reaches the position
            if (status.idx_at_pos) begin
               cmd.wr_en   = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.rsp_en  = 1'b1;
               cmd.rsp_ok  = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               state_in   = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = S_INS_RD;
         end
         S_DEL_RD: begin
            // close the gap until the last entry is reached
            if (status.idx_last) begin
               cmd.cnt_dec = 1'b1;
               cmd.rsp_en  = 1'b1;
               cmd.rsp_ok  = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_DEL_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### design/indexed_list_insert_delete_core.sv
// Top level of the indexed list core: controller and datapath.
// Depends on ilist_pkg, ilist_ctrl and ilist_datapath.
//
// channel   ports                                     handshake
// request   req_op, req_position, req_item_value      start high, busy low
// response  rsp_read_value, rsp_ok, rsp_entry_count   rsp_strobe, one cycle
//
// A read passes the check and read-wait states before the strobe; a failed
// request goes from the check straight to the strobe. An insert moves
// count - position entries and a delete count - 1 - position: each moved
// entry costs one read and one write on the entry storage.
// Synchronous reset empties the list; entries are not cleared.
// The response is never stalled; busy drops with the strobe.
module indexed_list_insert_delete_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_op,
   input  logic [ilist_pkg::POS_W-1:0]          req_position,
   input  logic signed [ilist_pkg::DATA_W-1:0]  req_item_value,
   output logic                                 rsp_strobe,
   output logic signed [ilist_pkg::DATA_W-1:0]  rsp_read_value,
   output logic                                 rsp_ok,
   output logic [ilist_pkg::POS_W-1:0]          rsp_entry_count
);
   import ilist_pkg::*;

   cmd_type    cmd;
   status_type status;

   ilist_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ilist_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_value  (rsp_read_value),
      .rsp_ok          (rsp_ok),
      .rsp_entry_count (rsp_entry_count)
   );

   // a strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held more than one cycle");

   // an accepted request makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   // count never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_count <= CAP_COUNT))
      else $error("entry count above capacity");

   // a failed request reports zero or the read failure value
   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_read_value == '0 || rsp_read_value == READ_FAIL))
      else $error("failed request with unexpected value");

endmodule
